[design/rde_pkg.sv]
`default_nettype none

package rde_pkg;

    localparam int VALUE_W             = 32;
    localparam int SYM_W               = 8;
    localparam int BASE_W              = 5;
    localparam int ALPHA_W             = 64;
    localparam int SYMS_PER_WORD       = ALPHA_W / SYM_W;
    localparam int CFG_INDEX_W         = 2;
    localparam int MAX_SYMBOLS_DEFAULT = 16;

    // Long division by the radix, this many dividend bits per cycle
    localparam int DIV_STEP    = 4;
    localparam int DIV_CYCLES  = VALUE_W / DIV_STEP;
    localparam int DIV_CNT_W   = $clog2(DIV_CYCLES);

    localparam int STACK_DEPTH = 32;
    localparam int STACK_AW    = $clog2(STACK_DEPTH);
    localparam int CNT_W       = STACK_AW + 1;

    localparam logic [SYM_W-1:0] SIGN_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] SIGN_MINUS = 8'h2D;

    localparam logic [CFG_INDEX_W-1:0] REG_BASE_LENGTH   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ALPHABET_LOW  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ALPHABET_HIGH = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_SIGN,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

[design/radix_digit_emitter.sv]
// Prints a signed 32-bit value as text in a configurable radix.
//
// Input channel s_*: one item is a value in s_tdata. Output channel m_*: one
// item per character, most significant first; a '-' leads for negative
// values and m_tlast marks the final character of the number.
// Configuration channel cfg_*: index 0 base_length (radix), 1 symbols 0-7,
// 2 symbols 8-15, one byte each, lowest byte first. cfg_ready is always high.
//
// Per item: the value is accepted, the alphabet is checked one symbol per cycle
// (up to MAX_SYMBOLS), digits come from the shared divider (four dividend
// bits a cycle), then one character per cycle is emitted while the receiver
// accepts. Only one value is in work at a time; s_tready is high between
// values, including while the last character still sits in the output
// register.
// An alphabet that is too short, too long, holds a zero byte, '+' or '-', or
// repeats a symbol causes the item to be dropped with no output.
// A stalled receiver holds the output register and pauses emission.
// Reset (aresetn low, synchronous) clears control and config, drops any item.
`default_nettype none

module radix_digit_emitter #(
    parameter int MAX_SYMBOLS = rde_pkg::MAX_SYMBOLS_DEFAULT
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,

    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [rde_pkg::VALUE_W-1:0]     s_tdata,   // [31:0] value

    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [rde_pkg::SYM_W-1:0]            m_tdata,   // [7:0] symbol
    output logic                                 m_tlast,   // is_last

    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [rde_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [rde_pkg::ALPHA_W-1:0]     cfg_data
);

    localparam int IDX_W = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;

    rde_pkg::state_t state_reg, state_next;

    logic [rde_pkg::BASE_W-1:0]    base_length_reg;
    logic [rde_pkg::SYM_W-1:0]     alpha_reg [MAX_SYMBOLS];
    logic [IDX_W-1:0]              stack_reg [rde_pkg::STACK_DEPTH];

    logic                          neg_reg, neg_next;
    logic [rde_pkg::VALUE_W-1:0]   work_reg, work_next;
    logic [rde_pkg::BASE_W-1:0]    rem_reg, rem_next;
    logic [rde_pkg::DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [IDX_W-1:0]              chk_idx_reg, chk_idx_next;
    logic [rde_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic                          out_valid_reg, out_valid_next;
    logic [rde_pkg::SYM_W-1:0]     out_sym_reg, out_sym_next;
    logic                          out_last_reg, out_last_next;

    logic                          base_ok;
    logic                          out_free;
    logic [rde_pkg::SYM_W-1:0]     chk_sym;
    logic                          chk_bad;
    logic                          chk_dup;
    logic [rde_pkg::VALUE_W-1:0]   div_w;
    logic [rde_pkg::BASE_W-1:0]    div_r;
    logic                          push;
    logic [rde_pkg::CNT_W-1:0]     cnt_m1;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == rde_pkg::ST_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_sym_reg;
    assign m_tlast   = out_last_reg;

    assign base_ok  = (base_length_reg >= rde_pkg::BASE_W'(2)) &&
                      (base_length_reg <= rde_pkg::BASE_W'(MAX_SYMBOLS));
    assign out_free = !out_valid_reg || m_tready;
    assign cnt_m1   = cnt_reg - rde_pkg::CNT_W'(1);

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_length_reg <= '0;
            for (int i = 0; i < MAX_SYMBOLS; i++) begin
                alpha_reg[i] <= '0;
            end
        end else if (cfg_valid) begin
            unique case (cfg_index)
                rde_pkg::REG_BASE_LENGTH: begin
                    base_length_reg <= cfg_data[rde_pkg::BASE_W-1:0];
                end
                rde_pkg::REG_ALPHABET_LOW: begin
                    for (int i = 0; i < MAX_SYMBOLS; i++) begin
                        if (i < rde_pkg::SYMS_PER_WORD) begin
                            alpha_reg[i] <=
                                cfg_data[rde_pkg::SYM_W*(i % rde_pkg::SYMS_PER_WORD) +: rde_pkg::SYM_W];
                        end
                    end
                end
                rde_pkg::REG_ALPHABET_HIGH: begin
                    for (int i = 0; i < MAX_SYMBOLS; i++) begin
                        if (i >= rde_pkg::SYMS_PER_WORD) begin
                            alpha_reg[i] <=
                                cfg_data[rde_pkg::SYM_W*(i % rde_pkg::SYMS_PER_WORD) +: rde_pkg::SYM_W];
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Alphabet check: one symbol per cycle against all later symbols in use
    always_comb begin
        chk_sym = alpha_reg[chk_idx_reg];
        chk_bad = (chk_sym == '0) || (chk_sym == rde_pkg::SIGN_PLUS) ||
                  (chk_sym == rde_pkg::SIGN_MINUS);
        chk_dup = 1'b0;
        for (int j = 0; j < MAX_SYMBOLS; j++) begin
            if ((IDX_W'(j) > chk_idx_reg) &&
                (rde_pkg::BASE_W'(j) < base_length_reg) &&
                (alpha_reg[j] == chk_sym)) begin
                chk_dup = 1'b1;
            end
        end
    end

    // Restoring division, DIV_STEP dividend bits per cycle; quotient bits
    // shift into the bottom of the work register as the dividend leaves the top
    always_comb begin
        logic [rde_pkg::BASE_W-1:0] trial;
        div_w = work_reg;
        div_r = rem_reg;
        for (int k = 0; k < rde_pkg::DIV_STEP; k++) begin
            trial = {div_r[rde_pkg::BASE_W-2:0], div_w[rde_pkg::VALUE_W-1]};
            if (trial >= base_length_reg) begin
                div_r = trial - base_length_reg;
                div_w = {div_w[rde_pkg::VALUE_W-2:0], 1'b1};
            end else begin
                div_r = trial;
                div_w = {div_w[rde_pkg::VALUE_W-2:0], 1'b0};
            end
        end
    end

    // Next state and outputs
    always_comb begin
        state_next     = state_reg;
        neg_next       = neg_reg;
        work_next      = work_reg;
        rem_next       = rem_reg;
        div_cnt_next   = div_cnt_reg;
        chk_idx_next   = chk_idx_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_sym_next   = out_sym_reg;
        out_last_next  = out_last_reg;
        push           = 1'b0;

        unique case (state_reg)
            rde_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    neg_next     = s_tdata[rde_pkg::VALUE_W-1];
                    work_next    = s_tdata[rde_pkg::VALUE_W-1] ?
                                   (rde_pkg::VALUE_W'(0) - s_tdata) : s_tdata;
                    chk_idx_next = '0;
                    if (base_ok) begin
                        state_next = rde_pkg::ST_CHECK;
                    end
                end
            end
            rde_pkg::ST_CHECK: begin
                if (chk_bad || chk_dup) begin
                    state_next = rde_pkg::ST_IDLE;
                end else if (rde_pkg::BASE_W'(chk_idx_reg) + rde_pkg::BASE_W'(1) ==
                             base_length_reg) begin
                    state_next   = rde_pkg::ST_DIVIDE;
                    div_cnt_next = '0;
                    rem_next     = '0;
                    cnt_next     = '0;
                end else begin
                    chk_idx_next = chk_idx_reg + IDX_W'(1);
                end
            end
            rde_pkg::ST_DIVIDE: begin
                work_next    = div_w;
                rem_next     = div_r;
                div_cnt_next = div_cnt_reg + rde_pkg::DIV_CNT_W'(1);
                if (div_cnt_reg == rde_pkg::DIV_CNT_W'(rde_pkg::DIV_CYCLES - 1)) begin
                    push         = 1'b1;
                    cnt_next     = cnt_reg + rde_pkg::CNT_W'(1);
                    rem_next     = '0;
                    div_cnt_next = '0;
                    if ((div_w == '0) ||
                        (cnt_reg == rde_pkg::CNT_W'(rde_pkg::STACK_DEPTH - 1))) begin
                        state_next = neg_reg ? rde_pkg::ST_SIGN : rde_pkg::ST_EMIT;
                    end
                end
            end
            rde_pkg::ST_SIGN: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_sym_next   = rde_pkg::SIGN_MINUS;
                    out_last_next  = 1'b0;
                    state_next     = rde_pkg::ST_EMIT;
                end
            end
            rde_pkg::ST_EMIT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_sym_next   = alpha_reg[stack_reg[cnt_m1[rde_pkg::STACK_AW-1:0]]];
                    out_last_next  = (cnt_reg == rde_pkg::CNT_W'(1));
                    cnt_next       = cnt_m1;
                    if (cnt_reg == rde_pkg::CNT_W'(1)) begin
                        state_next = rde_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = rde_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rde_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_cnt_reg   <= '0;
            chk_idx_reg   <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            div_cnt_reg   <= div_cnt_next;
            chk_idx_reg   <= chk_idx_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        neg_reg      <= neg_next;
        work_reg     <= work_next;
        rem_reg      <= rem_next;
        out_sym_reg  <= out_sym_next;
        out_last_reg <= out_last_next;
    end

    // Digit stack, least significant digit pushed first
    always_ff @(posedge aclk) begin
        if (push) begin
            stack_reg[cnt_reg[rde_pkg::STACK_AW-1:0]] <= div_r[IDX_W-1:0];
        end
    end

    a_rem_below_radix: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rde_pkg::ST_DIVIDE) |-> (rem_reg < base_length_reg))
        else $error("partial remainder not below the radix");

    a_cnt_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= rde_pkg::CNT_W'(rde_pkg::STACK_DEPTH))
        else $error("digit count beyond stack depth");

    a_emit_has_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rde_pkg::ST_EMIT) |-> (cnt_reg != '0))
        else $error("emitting with an empty digit stack");

    a_sign_only_negative: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rde_pkg::ST_SIGN) |-> neg_reg)
        else $error("sign stage entered for a non-negative value");

    a_last_ends_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rde_pkg::ST_EMIT && out_free && cnt_reg == rde_pkg::CNT_W'(1))
        |=> (m_tvalid && m_tlast && state_reg == rde_pkg::ST_IDLE))
        else $error("final character not marked or block not back to idle");

endmodule

`default_nettype wire
